FILE: hw/rtl/whp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the wav header parser
// depends on nothing; wav_header_parser imports it

package whp_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// format codes
	localparam logic [2:0] FMT_UNSET    = 3'd0;
	localparam logic [2:0] FMT_MONO8    = 3'd1;
	localparam logic [2:0] FMT_STEREO8  = 3'd3;

	// error codes
	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_SMALL    = 4'd1;
	localparam logic [3:0] ERR_NO_RIFF  = 4'd2;
	localparam logic [3:0] ERR_NO_WAVE  = 4'd3;
	localparam logic [3:0] ERR_OVERRUN  = 4'd4;
	localparam logic [3:0] ERR_FMT_SIZE = 4'd5;
	localparam logic [3:0] ERR_NOT_PCM  = 4'd6;
	localparam logic [3:0] ERR_BITS     = 4'd7;
	localparam logic [3:0] ERR_CHANNELS = 4'd8;

	// chunk tags as read big-endian
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] MIN_FILE_SIZE = 32'd12;
	localparam logic [31:0] FMT_SIZE      = 32'd16;
	localparam int          CHUNK_HDR_LEN = 8;

	// one result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [2:0]  format_code;
		logic [1:0]  channel_count;
		logic [4:0]  sample_bits;
		logic [31:0] sample_rate;
		logic [31:0] data_length;
		logic [3:0]  error_code;
		logic        last;
	} result_t;

	// expected byte of the riff header, positions 0..3 and 8..11
	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] v;
		begin
			unique case (idx)
				4'd0:    v = 8'h52; // R
				4'd1:    v = 8'h49; // I
				4'd2:    v = 8'h46; // F
				4'd3:    v = 8'h46; // F
				4'd8:    v = 8'h57; // W
				4'd9:    v = 8'h41; // A
				4'd10:   v = 8'h56; // V
				4'd11:   v = 8'h45; // E
				default: v = 8'h00;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: hw/rtl/whp_in_if.sv
`timescale 1ns / 1ps
// byte channel into the wav header parser
// depends on nothing

interface whp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_file;

	modport source (output valid, output data_byte, output new_file, input ready);
	modport sink (input valid, input data_byte, input new_file, output ready);
endinterface

FILE: hw/rtl/whp_out_if.sv
`timescale 1ns / 1ps
// result channel out of the wav header parser
// depends on nothing

interface whp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [2:0]  format_code;
	logic [1:0]  channel_count;
	logic [4:0]  sample_bits;
	logic [31:0] sample_rate;
	logic [31:0] data_length;
	logic [3:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output byte_value, output format_code,
		output channel_count, output sample_bits, output sample_rate,
		output data_length, output error_code, output last, input ready);
	modport sink (input valid, input kind, input byte_value, input format_code,
		input channel_count, input sample_bits, input sample_rate,
		input data_length, input error_code, input last, output ready);
endinterface

FILE: hw/rtl/wav_header_parser.sv
`timescale 1ns / 1ps
// wav header parser top level: riff/wave chunk walker with a result queue
// depends on whp_pkg, whp_in_if, whp_out_if

// Streams a WAV file one byte per item, with the file length written to the
// file_size register before the first byte (marked by new_file). One byte is
// accepted every clock cycle as long as the four-entry result queue has room
// for two results; all parsing of a byte happens in the cycle it is accepted
// and its results are registered in the queue, which drives the output. A byte yields at
// most two results (format known or a data byte, followed by file done) and
// the queue drains one result per cycle, so the sustained rate is one byte per
// cycle whenever the output side takes one result per cycle. Errors are
// reported once; afterwards the block drops bytes until the next new_file.
module wav_header_parser
	import whp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	whp_in_if.sink      bytes,
	whp_out_if.source   results
);

	// parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_FMT    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_SKIP   = 3'd5;
	localparam logic [2:0] PH_TRAIL  = 3'd6;
	localparam logic [2:0] PH_STOP   = 3'd7;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	logic [31:0] file_size_q;
	logic [2:0]  ph_q, n_ph;
	logic [32:0] pos_q, n_pos;
	logic [2:0]  fbc_q, n_fbc;
	logic [31:0] tag_q, n_tag;
	logic [31:0] acc_q, n_acc;
	logic [31:0] left_q, n_left;
	logic [15:0] ch_q, n_ch;
	logic [15:0] bits_q, n_bits;
	logic [31:0] rate_q, n_rate;
	logic [2:0]  fmt_q, n_fmt;
	logic [31:0] dlen_q, n_dlen;

	logic [33:0] pos_inc;
	logic [4:0]  off;
	logic        err;
	logic [3:0]  err_code;
	logic        chunk_go;
	logic [1:0]  nres;
	result_t     res0, res1;

	logic        accept;
	logic        pop;
	result_t     queue_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_wr_en) begin
			file_size_q <= cfg_wr_data;
		end
	end

	// per-byte parse step
	always_comb begin
		n_ph = ph_q;
		n_pos = pos_q;
		n_fbc = fbc_q;
		n_tag = tag_q;
		n_acc = acc_q;
		n_left = left_q;
		n_ch = ch_q;
		n_bits = bits_q;
		n_rate = rate_q;
		n_fmt = fmt_q;
		n_dlen = dlen_q;
		err = 1'b0;
		err_code = ERR_NONE;
		chunk_go = 1'b0;
		nres = 2'd0;
		res0 = '0;
		res1 = '0;
		pos_inc = '0;
		off = '0;

		// restart on a new file
		if (bytes.new_file) begin
			n_ph = PH_MAGIC;
			n_pos = '0;
			n_fbc = '0;
			n_tag = '0;
			n_acc = '0;
			n_left = '0;
			n_ch = '0;
			n_bits = '0;
			n_rate = '0;
			n_fmt = FMT_UNSET;
			n_dlen = '0;
			if (file_size_q < MIN_FILE_SIZE) begin
				err = 1'b1;
				err_code = ERR_SMALL;
			end
		end

		if (!err && n_ph != PH_IDLE && n_ph != PH_STOP) begin
			pos_inc = {1'b0, n_pos} + 34'd1;
			unique case (n_ph)
				PH_MAGIC: begin
					if (n_pos < 33'd4 && bytes.data_byte != magic_byte(n_pos[3:0])) begin
						err = 1'b1;
						err_code = ERR_NO_RIFF;
					end else if (n_pos >= 33'd8 && n_pos < 33'd12
						&& bytes.data_byte != magic_byte(n_pos[3:0])) begin
						err = 1'b1;
						err_code = ERR_NO_WAVE;
					end else if (n_pos >= 33'd11) begin
						chunk_go = 1'b1;
					end
				end
				PH_HEADER: begin
					// tag big-endian, size little-endian
					if (!n_fbc[2]) begin
						n_tag = {n_tag[23:0], bytes.data_byte};
					end else begin
						n_acc = n_acc | ({24'd0, bytes.data_byte} << {n_fbc[1:0], 3'd0});
					end
					n_fbc = n_fbc + 3'd1;
					if (n_fbc == 3'd0) begin
						n_left = n_acc;
						n_acc = '0;
						if ({1'b0, pos_inc} + {3'd0, n_left} > {3'd0, file_size_q}) begin
							err = 1'b1;
							err_code = ERR_OVERRUN;
						end else begin
							if (n_tag == TAG_FMT) begin
								if (n_left != FMT_SIZE) begin
									err = 1'b1;
									err_code = ERR_FMT_SIZE;
								end
								n_ph = PH_FMT;
							end else if (n_tag == TAG_DATA) begin
								n_dlen = n_left;
								n_ph = PH_DATA;
							end else begin
								n_ph = PH_SKIP;
							end
							if (n_left == '0) begin
								chunk_go = 1'b1;
							end
						end
					end
				end
				PH_FMT: begin
					off = 5'd16 - n_left[4:0];
					// assemble the little-endian fmt fields
					if (off == 5'd0 || off == 5'd2 || off == 5'd4 || off == 5'd14) begin
						n_acc = {24'd0, bytes.data_byte};
					end else if (off == 5'd5) begin
						n_acc = n_acc | {16'd0, bytes.data_byte, 8'd0};
					end else if (off == 5'd6) begin
						n_acc = n_acc | {8'd0, bytes.data_byte, 16'd0};
					end else if (off == 5'd7) begin
						n_acc = n_acc | {bytes.data_byte, 24'd0};
					end else if (off == 5'd1 || off == 5'd3 || off == 5'd15) begin
						n_acc = n_acc | {16'd0, bytes.data_byte, 8'd0};
					end
					if (off == 5'd1 && n_acc[15:0] != 16'd1) begin
						err = 1'b1;
						err_code = ERR_NOT_PCM;
					end
					if (off == 5'd3) begin
						n_ch = n_acc[15:0];
					end
					if (off == 5'd7) begin
						n_rate = n_acc;
					end
					if (!err && off == 5'd15) begin
						n_bits = n_acc[15:0];
						if (n_ch != 16'd1 && n_ch != 16'd2) begin
							err = 1'b1;
							err_code = ERR_CHANNELS;
						end else if (n_bits != 16'd8 && n_bits != 16'd16) begin
							err = 1'b1;
							err_code = ERR_BITS;
						end else begin
							n_fmt = ((n_ch == 16'd1) ? FMT_MONO8 : FMT_STEREO8)
								+ ((n_bits == 16'd16) ? 3'd1 : 3'd0);
							res0.kind = KIND_FORMAT;
							res0.format_code = n_fmt;
							res0.channel_count = n_ch[1:0];
							res0.sample_bits = n_bits[4:0];
							res0.sample_rate = n_rate;
							nres = 2'd1;
						end
					end
					n_left = n_left - 32'd1;
					if (n_left == '0 || off >= 5'd15) begin
						chunk_go = 1'b1;
					end
				end
				PH_DATA, PH_SKIP: begin
					if (n_ph == PH_DATA) begin
						res0.kind = KIND_DATA;
						res0.byte_value = bytes.data_byte;
						nres = 2'd1;
					end
					if (n_left != '0) begin
						n_left = n_left - 32'd1;
					end
					if (n_left == '0) begin
						chunk_go = 1'b1;
					end
				end
				default: begin
				end
			endcase

			// start of the next chunk header, or trailing bytes
			if (chunk_go) begin
				n_fbc = '0;
				n_tag = '0;
				n_acc = '0;
				n_ph = ({1'b0, pos_inc} + 35'(CHUNK_HDR_LEN) <= {3'd0, file_size_q})
					? PH_HEADER : PH_TRAIL;
			end

			// advance position and close the file at its last byte
			if (!err) begin
				n_pos = pos_inc[32:0];
				if (pos_inc >= {2'd0, file_size_q}) begin
					if (nres == 2'd0) begin
						res0.kind = KIND_DONE;
						res0.format_code = n_fmt;
						res0.channel_count = n_ch[1:0];
						res0.sample_bits = n_bits[4:0];
						res0.sample_rate = n_rate;
						res0.data_length = n_dlen;
					end else begin
						res1.kind = KIND_DONE;
						res1.format_code = n_fmt;
						res1.channel_count = n_ch[1:0];
						res1.sample_bits = n_bits[4:0];
						res1.sample_rate = n_rate;
						res1.data_length = n_dlen;
					end
					nres = nres + 2'd1;
					n_ph = PH_STOP;
				end
			end
		end

		// an error replaces any other result of this byte
		if (err) begin
			n_ph = PH_STOP;
			res0 = '0;
			res1 = '0;
			res0.kind = KIND_ERROR;
			res0.error_code = err_code;
			nres = 2'd1;
		end

		// mark the final result of the byte
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

	// handshakes
	assign bytes.ready = (count_q <= (QAW+1)'(QDEPTH - 2));
	assign accept = bytes.valid && bytes.ready;
	assign pop = results.valid && results.ready;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			pos_q <= '0;
			fbc_q <= '0;
			tag_q <= '0;
			acc_q <= '0;
			left_q <= '0;
			ch_q <= '0;
			bits_q <= '0;
			rate_q <= '0;
			fmt_q <= FMT_UNSET;
			dlen_q <= '0;
		end else if (accept) begin
			ph_q <= n_ph;
			pos_q <= n_pos;
			fbc_q <= n_fbc;
			tag_q <= n_tag;
			acc_q <= n_acc;
			left_q <= n_left;
			ch_q <= n_ch;
			bits_q <= n_bits;
			rate_q <= n_rate;
			fmt_q <= n_fmt;
			dlen_q <= n_dlen;
		end
	end

	// result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (accept ? QAW'(nres) : QAW'(0));
			rd_ptr_q <= rd_ptr_q + (pop ? QAW'(1) : QAW'(0));
			count_q <= count_q + (accept ? (QAW+1)'(nres) : (QAW+1)'(0))
				- (pop ? (QAW+1)'(1) : (QAW+1)'(0));
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (accept && nres != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (accept && nres == 2'd2) begin
			queue_q[wr_ptr_q + QAW'(1)] <= res1;
		end
	end

	// output side
	assign results.valid = (count_q != '0);
	assign results.kind = queue_q[rd_ptr_q].kind;
	assign results.byte_value = queue_q[rd_ptr_q].byte_value;
	assign results.format_code = queue_q[rd_ptr_q].format_code;
	assign results.channel_count = queue_q[rd_ptr_q].channel_count;
	assign results.sample_bits = queue_q[rd_ptr_q].sample_bits;
	assign results.sample_rate = queue_q[rd_ptr_q].sample_rate;
	assign results.data_length = queue_q[rd_ptr_q].data_length;
	assign results.error_code = queue_q[rd_ptr_q].error_code;
	assign results.last = queue_q[rd_ptr_q].last;

endmodule
